// ===== hw/rtl/llm_pkg.sv =====
// Shared types, constants and word-format helpers for the linked list manager.
// No dependencies; imported by llm_ctrl, linked_list_manager_unit and the testbench.
`default_nettype none

package llm_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;

    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int MODE_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 4;
    localparam int CMP_W    = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    typedef enum logic [MODE_W-1:0] {
        MD_INS_FRONT = 3'd0,
        MD_INS_END   = 3'd1,
        MD_INS_AT    = 3'd2,
        MD_DEL_FRONT = 3'd3,
        MD_DEL_END   = 3'd4,
        MD_DEL_AT    = 3'd5,
        MD_DUMP      = 3'd6
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK     = 2'd0,
        STS_EMPTY  = 2'd1,
        STS_FULL   = 2'd2,
        STS_BADPOS = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        OP_INS_FRONT,
        OP_INS_END,
        OP_INS_MID,
        OP_DEL_FRONT,
        OP_DEL_END,
        OP_DEL_MID
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_ALLOC,
        S_ALLOC_W,
        S_INS_A,
        S_INS_B,
        S_DEL_A,
        S_DEL_B,
        S_DUMP_RD,
        S_DUMP_OUT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic                  we;
        logic [SLOT_W-1:0]     waddr;
        logic [DATA_WIDTH-1:0] wdata;
        logic                  re;
        logic [SLOT_W-1:0]     raddr;
    } t_val_req;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [SLOT_W-1:0] wdata;
        logic              re;
        logic [SLOT_W-1:0] raddr;
    } t_nxt_req;

    typedef struct packed {
        t_status              status;
        logic [VALUE_W-1:0]   value;
        logic [INDEX_W-1:0]   index;
        logic                 last;
    } t_result;

    // input word -> stored form (sign-extended or truncated to DATA_WIDTH)
    function automatic logic [DATA_WIDTH-1:0] to_store(input logic [VALUE_W-1:0] v);
        logic signed [63:0] t;
        t = 64'(signed'(v));
        return t[DATA_WIDTH-1:0];
    endfunction

    // stored word -> 32-bit result field
    function automatic logic [VALUE_W-1:0] to_report(input logic [DATA_WIDTH-1:0] w);
        logic signed [63:0] t;
        t = 64'(signed'(w));
        return t[VALUE_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/llm_ram.sv =====
// Generic single-write, single-read RAM with registered, enabled read port.
// No dependencies.
`default_nettype none

module llm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/llm_ctrl.sv =====
// Sequencer for the linked list manager: list registers, pointer walker and
// slot allocator. Drives both node RAMs. Depends on llm_pkg.
`default_nettype none

module llm_ctrl (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [llm_pkg::MODE_W-1:0]       i_mode,
    input  wire logic [llm_pkg::VALUE_W-1:0]      i_value,
    input  wire logic [llm_pkg::POS_W-1:0]        i_position,
    input  wire logic                             i_out_free,
    output logic                                  o_push,
    output llm_pkg::t_result                      o_result,
    output llm_pkg::t_val_req                     o_vreq,
    output llm_pkg::t_nxt_req                     o_nreq,
    input  wire logic [llm_pkg::DATA_WIDTH-1:0]   i_vrdata,
    input  wire logic [llm_pkg::SLOT_W-1:0]       i_nrdata
);

    import llm_pkg::*;

    t_state                r_state, n_state;
    logic [SLOT_W-1:0]     r_head, n_head;
    logic [SLOT_W-1:0]     r_tail, n_tail;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [SLOT_W-1:0]     r_free, n_free;
    logic [CNT_W-1:0]      r_mark, n_mark;

    t_mode                 r_mode, n_mode;
    logic [DATA_WIDTH-1:0] r_word, n_word;
    logic [POS_W-1:0]      r_pos, n_pos;
    t_op                   r_op, n_op;
    t_status               r_status, n_status;
    logic                  r_has_val, n_has_val;
    logic [SLOT_W-1:0]     r_cur, n_cur;
    logic [SLOT_W-1:0]     r_prev, n_prev;
    logic [SLOT_W-1:0]     r_pprev, n_pprev;
    logic                  r_pend, n_pend;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [SLOT_W-1:0]     r_slot, n_slot;
    logic [CNT_W-1:0]      r_idx, n_idx;

    logic [SLOT_W-1:0]     cur;
    logic [SLOT_W-1:0]     victim;
    logic [CMP_W-1:0]      pos_x, cnt_x;
    logic                  full, empty, dump_last, recycle;
    logic                  d_err;
    t_status               d_status;
    t_op                   d_op;
    logic [CNT_W-1:0]      d_k;

    // while walking, the current slot sits in the next-pointer RAM output
    assign cur       = r_pend ? i_nrdata : r_cur;
    assign victim    = (r_op == OP_DEL_END) ? r_tail : r_prev;
    assign pos_x     = CMP_W'(r_pos);
    assign cnt_x     = CMP_W'(r_count);
    assign full      = (r_count >= CNT_W'(CAPACITY));
    assign empty     = (r_count == '0);
    assign dump_last = ((r_idx + CNT_W'(1)) == r_count);
    assign recycle   = (r_mark > r_count);
    assign o_in_stall = (r_state != S_IDLE);

    // operation decode and checks
    always_comb begin
        d_err    = 1'b0;
        d_status = STS_OK;
        d_op     = OP_INS_FRONT;
        case (r_mode)
            MD_INS_FRONT, MD_INS_END, MD_INS_AT: begin
                if (full) begin
                    d_err    = 1'b1;
                    d_status = STS_FULL;
                end else if (r_mode == MD_INS_AT &&
                             (pos_x == '0 || pos_x > cnt_x + CMP_W'(1))) begin
                    d_err    = 1'b1;
                    d_status = STS_BADPOS;
                end else if (r_mode == MD_INS_FRONT ||
                             (r_mode == MD_INS_AT && pos_x == CMP_W'(1))) begin
                    d_op = OP_INS_FRONT;
                end else if (r_mode == MD_INS_END || pos_x == cnt_x + CMP_W'(1)) begin
                    d_op = OP_INS_END;
                end else begin
                    d_op = OP_INS_MID;
                end
            end
            MD_DEL_FRONT, MD_DEL_END, MD_DEL_AT: begin
                if (empty) begin
                    d_err    = 1'b1;
                    d_status = STS_EMPTY;
                end else if (r_mode == MD_DEL_AT && (pos_x == '0 || pos_x > cnt_x)) begin
                    d_err    = 1'b1;
                    d_status = STS_BADPOS;
                end else if (r_mode == MD_DEL_FRONT ||
                             (r_mode == MD_DEL_AT && pos_x == CMP_W'(1)) ||
                             (r_mode == MD_DEL_END && r_count == CNT_W'(1))) begin
                    d_op = OP_DEL_FRONT;
                end else if (r_mode == MD_DEL_END || pos_x == cnt_x) begin
                    d_op = OP_DEL_END;
                end else begin
                    d_op = OP_DEL_MID;
                end
            end
            MD_DUMP: begin
                if (empty) begin
                    d_err    = 1'b1;
                    d_status = STS_EMPTY;
                end
            end
            default: ;
        endcase
    end

    // walk length in hops from the head
    always_comb begin
        case (d_op)
            OP_INS_MID:   d_k = CNT_W'(pos_x - CMP_W'(1));
            OP_DEL_MID:   d_k = CNT_W'(pos_x);
            OP_DEL_FRONT: d_k = CNT_W'(1);
            OP_DEL_END:   d_k = r_count - CNT_W'(2);
            default:      d_k = '0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (r_mode)
                    MD_INS_FRONT, MD_INS_END, MD_INS_AT,
                    MD_DEL_FRONT, MD_DEL_END, MD_DEL_AT: begin
                        if (d_err) begin
                            n_state = S_EMIT;
                        end else if (d_op == OP_INS_FRONT || d_op == OP_INS_END) begin
                            n_state = S_ALLOC;
                        end else begin
                            n_state = S_WALK;
                        end
                    end
                    MD_DUMP: n_state = d_err ? S_EMIT : S_DUMP_RD;
                    default: n_state = S_IDLE;
                endcase
            end
            S_WALK: begin
                if (r_cnt == '0) begin
                    n_state = (r_op == OP_INS_MID) ? S_ALLOC : S_DEL_A;
                end
            end
            S_ALLOC:    n_state = recycle ? S_ALLOC_W : S_INS_A;
            S_ALLOC_W:  n_state = S_INS_A;
            S_INS_A:    n_state = (r_op == OP_INS_MID) ? S_INS_B : S_EMIT;
            S_INS_B:    n_state = S_EMIT;
            S_DEL_A:    n_state = (r_op == OP_DEL_MID) ? S_DEL_B : S_EMIT;
            S_DEL_B:    n_state = S_EMIT;
            S_DUMP_RD:  n_state = S_DUMP_OUT;
            S_DUMP_OUT: begin
                if (i_out_free && dump_last) begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath, RAM requests and result
    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_free    = r_free;
        n_mark    = r_mark;
        n_mode    = r_mode;
        n_word    = r_word;
        n_pos     = r_pos;
        n_op      = r_op;
        n_status  = r_status;
        n_has_val = r_has_val;
        n_cur     = r_cur;
        n_prev    = r_prev;
        n_pprev   = r_pprev;
        n_pend    = r_pend;
        n_cnt     = r_cnt;
        n_slot    = r_slot;
        n_idx     = r_idx;
        o_vreq    = '0;
        o_nreq    = '0;
        o_push    = 1'b0;
        o_result  = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode = t_mode'(i_mode);
                    n_word = to_store(i_value);
                    n_pos  = i_position;
                end
            end
            S_DECODE: begin
                n_op      = d_op;
                n_status  = d_status;
                n_has_val = 1'b0;
                n_cur     = r_head;
                n_pend    = 1'b0;
                n_cnt     = d_k;
                n_idx     = '0;
            end
            S_WALK: begin
                if (r_cnt == '0) begin
                    n_cur  = cur;
                    n_pend = 1'b0;
                end else begin
                    o_nreq.re    = 1'b1;
                    o_nreq.raddr = cur;
                    n_pend       = 1'b1;
                    n_pprev      = r_prev;
                    n_prev       = cur;
                    n_cnt        = r_cnt - CNT_W'(1);
                end
            end
            S_ALLOC: begin
                if (recycle) begin
                    // pop the free list; its successor arrives next cycle
                    o_nreq.re    = 1'b1;
                    o_nreq.raddr = r_free;
                    n_slot       = r_free;
                end else begin
                    n_slot = r_mark[SLOT_W-1:0];
                    n_mark = r_mark + CNT_W'(1);
                end
            end
            S_ALLOC_W: begin
                n_free = i_nrdata;
            end
            S_INS_A: begin
                o_vreq.we    = 1'b1;
                o_vreq.waddr = r_slot;
                o_vreq.wdata = r_word;
                case (r_op)
                    OP_INS_FRONT: begin
                        o_nreq.we    = 1'b1;
                        o_nreq.waddr = r_slot;
                        o_nreq.wdata = r_head;
                        n_head       = r_slot;
                        if (empty) begin
                            n_tail = r_slot;
                        end
                        n_count = r_count + CNT_W'(1);
                    end
                    OP_INS_END: begin
                        if (empty) begin
                            n_head = r_slot;
                        end else begin
                            o_nreq.we    = 1'b1;
                            o_nreq.waddr = r_tail;
                            o_nreq.wdata = r_slot;
                        end
                        n_tail  = r_slot;
                        n_count = r_count + CNT_W'(1);
                    end
                    default: begin
                        o_nreq.we    = 1'b1;
                        o_nreq.waddr = r_slot;
                        o_nreq.wdata = r_cur;
                    end
                endcase
            end
            S_INS_B: begin
                o_nreq.we    = 1'b1;
                o_nreq.waddr = r_prev;
                o_nreq.wdata = r_slot;
                n_count      = r_count + CNT_W'(1);
            end
            S_DEL_A: begin
                o_vreq.re    = 1'b1;
                o_vreq.raddr = victim;
                n_has_val    = 1'b1;
                if (r_op == OP_DEL_MID) begin
                    // unlink: predecessor now points past the victim
                    o_nreq.we    = 1'b1;
                    o_nreq.waddr = r_pprev;
                    o_nreq.wdata = r_cur;
                end else begin
                    o_nreq.we    = 1'b1;
                    o_nreq.waddr = victim;
                    o_nreq.wdata = r_free;
                    n_free       = victim;
                    n_count      = r_count - CNT_W'(1);
                    if (r_op == OP_DEL_FRONT) begin
                        if (r_count == CNT_W'(1)) begin
                            n_head = '0;
                            n_tail = '0;
                        end else begin
                            n_head = r_cur;
                        end
                    end else begin
                        n_tail = r_cur;
                    end
                end
            end
            S_DEL_B: begin
                o_nreq.we    = 1'b1;
                o_nreq.waddr = r_prev;
                o_nreq.wdata = r_free;
                n_free       = r_prev;
                n_count      = r_count - CNT_W'(1);
            end
            S_DUMP_RD: begin
                o_vreq.re    = 1'b1;
                o_vreq.raddr = cur;
                o_nreq.re    = 1'b1;
                o_nreq.raddr = cur;
                n_pend       = 1'b1;
            end
            S_DUMP_OUT: begin
                if (i_out_free) begin
                    o_push          = 1'b1;
                    o_result.status = STS_OK;
                    o_result.value  = to_report(i_vrdata);
                    o_result.index  = INDEX_W'(r_idx);
                    o_result.last   = dump_last;
                    if (!dump_last) begin
                        o_vreq.re    = 1'b1;
                        o_vreq.raddr = cur;
                        o_nreq.re    = 1'b1;
                        o_nreq.raddr = cur;
                        n_idx        = r_idx + CNT_W'(1);
                    end
                end
            end
            S_EMIT: begin
                if (i_out_free) begin
                    o_push          = 1'b1;
                    o_result.status = r_status;
                    o_result.value  = r_has_val ? to_report(i_vrdata) : '0;
                    o_result.index  = '0;
                    o_result.last   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_free  <= '0;
            r_mark  <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_free  <= n_free;
            r_mark  <= n_mark;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_word    <= n_word;
        r_pos     <= n_pos;
        r_op      <= n_op;
        r_status  <= n_status;
        r_has_val <= n_has_val;
        r_cur     <= n_cur;
        r_prev    <= n_prev;
        r_pprev   <= n_pprev;
        r_pend    <= n_pend;
        r_cnt     <= n_cnt;
        r_slot    <= n_slot;
        r_idx     <= n_idx;
    end

`ifndef SYNTH
    a_mark_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mark >= r_count) && (r_mark <= CNT_W'(CAPACITY)))
        else $error("watermark out of range");

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> i_out_free)
        else $error("result pushed into a full output register");

    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_count == '0) |-> (r_head == '0 && r_tail == '0))
        else $error("empty list with nonzero head or tail");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_result.last) |=> (r_state == S_IDLE))
        else $error("sequencer busy after final result");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/linked_list_manager_unit.sv =====
// Channel   | Signals                                         | Direction
// ----------+-------------------------------------------------+----------
// command   | i_in_valid, o_in_stall, i_mode, i_value,        | in
//           | i_position                                      |
// result    | o_out_valid, i_out_stall, o_status,             | out
//           | o_element_value, o_element_index, o_last        |
//
// One command at a time. Reusing a freed slot adds the S_ALLOC_W state to an insert.
// Insert/delete at a position and delete at end walk the list from the head; dump
// reads it in order. Pointer walks run one hop per cycle on the next-pointer RAM
// read port. Reset is synchronous; node RAMs are not cleared. An output register
// holds each result, so the next command is taken while a result waits on i_out_stall.
// Top level: node RAMs, sequencer and result register. Depends on llm_pkg,
// llm_ram and llm_ctrl.
`default_nettype none

module linked_list_manager_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [llm_pkg::MODE_W-1:0]    i_mode,
    input  wire logic [llm_pkg::VALUE_W-1:0]   i_value,
    input  wire logic [llm_pkg::POS_W-1:0]     i_position,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [llm_pkg::STATUS_W-1:0]       o_status,
    output logic [llm_pkg::VALUE_W-1:0]        o_element_value,
    output logic [llm_pkg::INDEX_W-1:0]        o_element_index,
    output logic                               o_last
);

    import llm_pkg::*;

    t_val_req              vreq;
    t_nxt_req              nreq;
    logic [DATA_WIDTH-1:0] vrdata;
    logic [SLOT_W-1:0]     nrdata;
    logic                  push;
    logic                  out_free;
    t_result               result;

    logic                  r_out_valid;
    t_result               r_out;

    assign out_free = !r_out_valid || !i_out_stall;

    llm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_mode     (i_mode),
        .i_value    (i_value),
        .i_position (i_position),
        .i_out_free (out_free),
        .o_push     (push),
        .o_result   (result),
        .o_vreq     (vreq),
        .o_nreq     (nreq),
        .i_vrdata   (vrdata),
        .i_nrdata   (nrdata)
    );

    llm_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (vreq.we),
        .i_waddr (vreq.waddr),
        .i_wdata (vreq.wdata),
        .i_re    (vreq.re),
        .i_raddr (vreq.raddr),
        .o_rdata (vrdata)
    );

    llm_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (CAPACITY)
    ) u_nxt_ram (
        .i_clk   (i_clk),
        .i_we    (nreq.we),
        .i_waddr (nreq.waddr),
        .i_wdata (nreq.wdata),
        .i_re    (nreq.re),
        .i_raddr (nreq.raddr),
        .o_rdata (nrdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out <= result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out.status;
    assign o_element_value = r_out.value;
    assign o_element_index = r_out.index;
    assign o_last          = r_out.last;

endmodule

`default_nettype wire

// ===== dv/tb_linked_list_manager_unit.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for linked_list_manager_unit: directed edge cases, then random
// grow/drain sequences with sender gaps and receiver stalls. Depends on llm_pkg and the RTL.
import llm_pkg::*;

class list_scoreboard;
    logic [DATA_WIDTH-1:0] slot_word [CAPACITY];
    logic [SLOT_W-1:0]     slot_link [CAPACITY];
    logic [SLOT_W-1:0]     head_slot;
    logic [SLOT_W-1:0]     tail_slot;
    logic [SLOT_W-1:0]     free_slot;
    int unsigned           length;
    int unsigned           watermark;
    t_result               due_results [$];
    int                    errors;

    function void clear();
        foreach (slot_word[i]) begin
            slot_word[i] = '0;
            slot_link[i] = '0;
        end
        head_slot = '0;
        tail_slot = '0;
        free_slot = '0;
        length    = 0;
        watermark = 0;
        errors    = 0;
        due_results.delete();
    endfunction

    function logic [DATA_WIDTH-1:0] stored_form(logic [VALUE_W-1:0] v);
        logic signed [63:0] ext;
        ext = 64'($signed(v));
        return ext[DATA_WIDTH-1:0];
    endfunction

    function logic [VALUE_W-1:0] reported_form(logic [DATA_WIDTH-1:0] w);
        logic signed [63:0] ext;
        ext = 64'($signed(w));
        return ext[VALUE_W-1:0];
    endfunction

    function void expect_result(t_status st, logic [VALUE_W-1:0] v, int unsigned idx,
                                logic fin);
        t_result r;
        r.status = st;
        r.value  = v;
        r.index  = idx[INDEX_W-1:0];
        r.last   = fin;
        due_results.push_back(r);
    endfunction

    function logic [SLOT_W-1:0] walk_to(int unsigned hops);
        logic [SLOT_W-1:0] s;
        s = head_slot;
        for (int unsigned i = 0; i < hops; i++)
            s = slot_link[s];
        return s;
    endfunction

    // recycled slots are used first; fresh slots only when the free list is empty
    function logic [SLOT_W-1:0] grab_slot(logic [DATA_WIDTH-1:0] w);
        logic [SLOT_W-1:0] s;
        if (watermark > length) begin
            s = free_slot;
            free_slot = slot_link[s];
        end else begin
            s = watermark[SLOT_W-1:0];
            watermark++;
        end
        slot_word[s] = w;
        slot_link[s] = '0;
        return s;
    endfunction

    function logic [DATA_WIDTH-1:0] release_slot(logic [SLOT_W-1:0] s);
        slot_link[s] = free_slot;
        free_slot = s;
        if (length > 0)
            length--;
        if (length == 0) begin
            head_slot = '0;
            tail_slot = '0;
        end
        return slot_word[s];
    endfunction

    function void note_command(logic [MODE_W-1:0] mode, logic [VALUE_W-1:0] value,
                               logic [POS_W-1:0] pos);
        int unsigned           p;
        logic [SLOT_W-1:0]     s;
        logic [SLOT_W-1:0]     prev;
        logic [DATA_WIDTH-1:0] gone;
        p = 32'(pos);
        case (mode)
            MD_INS_FRONT, MD_INS_END, MD_INS_AT: begin
                if (length >= CAPACITY) begin
                    expect_result(STS_FULL, '0, 0, 1'b1);
                end else if (mode == MD_INS_AT && (p == 0 || p > length + 1)) begin
                    expect_result(STS_BADPOS, '0, 0, 1'b1);
                end else begin
                    if (mode == MD_INS_FRONT || (mode == MD_INS_AT && p == 1)) begin
                        s = grab_slot(stored_form(value));
                        if (length == 0)
                            tail_slot = s;
                        else
                            slot_link[s] = head_slot;
                        head_slot = s;
                    end else if (mode == MD_INS_END || p == length + 1) begin
                        s = grab_slot(stored_form(value));
                        if (length == 0)
                            head_slot = s;
                        else
                            slot_link[tail_slot] = s;
                        tail_slot = s;
                    end else begin
                        prev = walk_to(p - 2);
                        s = grab_slot(stored_form(value));
                        slot_link[s] = slot_link[prev];
                        slot_link[prev] = s;
                    end
                    length++;
                    expect_result(STS_OK, '0, 0, 1'b1);
                end
            end
            MD_DEL_FRONT, MD_DEL_END, MD_DEL_AT: begin
                if (length == 0) begin
                    expect_result(STS_EMPTY, '0, 0, 1'b1);
                end else if (mode == MD_DEL_AT && (p == 0 || p > length)) begin
                    expect_result(STS_BADPOS, '0, 0, 1'b1);
                end else begin
                    // a single element is always taken from the front
                    if (mode == MD_DEL_FRONT || (mode == MD_DEL_AT && p == 1) || length == 1)
                    begin
                        s = head_slot;
                        head_slot = slot_link[s];
                    end else if (mode == MD_DEL_END || p == length) begin
                        prev = walk_to(length - 2);
                        s = tail_slot;
                        tail_slot = prev;
                    end else begin
                        prev = walk_to(p - 2);
                        s = slot_link[prev];
                        slot_link[prev] = slot_link[s];
                    end
                    gone = release_slot(s);
                    expect_result(STS_OK, reported_form(gone), 0, 1'b1);
                end
            end
            MD_DUMP: begin
                if (length == 0) begin
                    expect_result(STS_EMPTY, '0, 0, 1'b1);
                end else begin
                    s = head_slot;
                    for (int unsigned i = 0; i < length; i++) begin
                        expect_result(STS_OK, reported_form(slot_word[s]), i, i + 1 == length);
                        s = slot_link[s];
                    end
                end
            end
            default: ;  // unused mode: no result
        endcase
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [VALUE_W-1:0] v,
                               logic [INDEX_W-1:0] idx, logic fin);
        t_result e;
        if (due_results.size() == 0) begin
            $display("%0t: unexpected result status=%0d value=%h index=%0d last=%0b",
                     $time, st, v, idx, fin);
            errors++;
            return;
        end
        e = due_results.pop_front();
        if (st !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, st);
            errors++;
        end
        if (v !== e.value) begin
            $display("%0t: element_value expected %h actual %h", $time, e.value, v);
            errors++;
        end
        if (idx !== e.index) begin
            $display("%0t: element_index expected %0d actual %0d", $time, e.index, idx);
            errors++;
        end
        if (fin !== e.last) begin
            $display("%0t: last expected %0b actual %0b", $time, e.last, fin);
            errors++;
        end
    endfunction
endclass

module tb_linked_list_manager_unit;
    localparam logic [MODE_W-1:0] MODE_UNUSED  = 3'd7;
    localparam int                RANDOM_ITEMS = 196;
    localparam int                CYCLE_LIMIT  = 200000;
    localparam int                DRAIN_CYCLES = 48;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_in_valid   = 1'b0;
    logic [MODE_W-1:0]     i_mode       = '0;
    logic [VALUE_W-1:0]    i_value      = '0;
    logic [POS_W-1:0]      i_position   = '0;
    logic                  i_out_stall  = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [STATUS_W-1:0]   o_status;
    logic [VALUE_W-1:0]    o_element_value;
    logic [INDEX_W-1:0]    o_element_index;
    logic                  o_last;

    list_scoreboard        list_sb;
    int unsigned           cycle_count = 0;
    int unsigned           stall_style = 0;
    int unsigned           stall_left  = 0;
    logic [31:0]           stall_tick  = '0;

    always #5 i_clk = ~i_clk;

    linked_list_manager_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_value         (i_value),
        .i_position      (i_position),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_element_value (o_element_value),
        .o_element_index (o_element_index),
        .o_last          (o_last)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_linked_list_manager_unit failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            list_sb.check_result(o_status, o_element_value, o_element_index, o_last);
    end

    // receiver back-pressure: free-flowing, random, alternating, or long stall runs
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_style = $urandom_range(0, 3);
            stall_left  = $urandom_range(20, 80);
        end
        stall_left--;
        stall_tick++;
        case (stall_style)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 99) < 35);
            2:       i_out_stall <= stall_tick[0];
            default: i_out_stall <= ((stall_tick % 7) < 5);
        endcase
    end

    task automatic drive_command(input logic [MODE_W-1:0] m, input logic [VALUE_W-1:0] v,
                                 input logic [POS_W-1:0] p);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_mode     <= m;
        i_value    <= v;
        i_position <= p;
        do @(posedge i_clk); while (o_in_stall);
        list_sb.note_command(m, v, p);
    endtask

    task automatic pause_sender(input int unsigned cycles);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    function automatic logic [VALUE_W-1:0] random_word();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    // growing phases favor inserts, draining phases favor deletes
    task automatic pick_command(input bit filling, output logic [MODE_W-1:0] m,
                                output logic [VALUE_W-1:0] v, output logic [POS_W-1:0] p);
        int unsigned roll;
        int unsigned len;
        len  = list_sb.length;
        roll = $urandom_range(0, 99);
        if (filling) begin
            if (roll < 25)      m = MD_INS_FRONT;
            else if (roll < 45) m = MD_INS_END;
            else if (roll < 70) m = MD_INS_AT;
            else if (roll < 78) m = MD_DEL_FRONT;
            else if (roll < 84) m = MD_DEL_END;
            else if (roll < 90) m = MD_DEL_AT;
            else if (roll < 97) m = MD_DUMP;
            else                m = MODE_UNUSED;
        end else begin
            if (roll < 20)      m = MD_DEL_FRONT;
            else if (roll < 40) m = MD_DEL_END;
            else if (roll < 65) m = MD_DEL_AT;
            else if (roll < 72) m = MD_INS_FRONT;
            else if (roll < 78) m = MD_INS_END;
            else if (roll < 84) m = MD_INS_AT;
            else if (roll < 95) m = MD_DUMP;
            else                m = MODE_UNUSED;
        end
        v = random_word();
        if ($urandom_range(0, 99) < 15)
            p = POS_W'($urandom_range(0, 31));
        else if (m == MD_INS_AT)
            p = POS_W'($urandom_range(1, len + 1));
        else
            p = POS_W'($urandom_range(1, (len == 0) ? 1 : len));
    endtask

    initial begin
        logic [MODE_W-1:0]  m;
        logic [VALUE_W-1:0] v;
        logic [POS_W-1:0]   p;
        bit                 filling;
        int unsigned        issued;
        int unsigned        burst;

        list_sb = new();
        list_sb.clear();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty list: every delete and dump reports empty, bad insert positions rejected
        drive_command(MD_DUMP,      32'h0000_0000, 5'd1);
        drive_command(MD_DEL_FRONT, 32'h0000_0000, 5'd1);
        drive_command(MD_DEL_END,   32'h0000_0000, 5'd1);
        drive_command(MD_DEL_AT,    32'h0000_0000, 5'd1);
        drive_command(MD_INS_AT,    32'h1234_5678, 5'd0);
        drive_command(MD_INS_AT,    32'h1234_5678, 5'd2);
        // build a short list through every insert flavor
        drive_command(MD_INS_AT,    32'h8000_0000, 5'd1);
        drive_command(MD_INS_END,   32'h7fff_ffff, 5'd1);
        drive_command(MD_INS_FRONT, 32'hffff_ffff, 5'd1);
        drive_command(MD_INS_AT,    32'h0000_0000, 5'd4);
        drive_command(MD_INS_AT,    32'h5555_5555, 5'd3);
        drive_command(MD_INS_AT,    32'h2222_2222, 5'd31);
        drive_command(MODE_UNUSED,  32'hdead_beef, 5'd31);
        drive_command(MD_DUMP,      32'h0000_0000, 5'd1);
        // deletes: bad positions, middle, end by position, end, front by position
        drive_command(MD_DEL_AT,    32'h0000_0000, 5'd0);
        drive_command(MD_DEL_AT,    32'h0000_0000, 5'd6);
        drive_command(MD_DEL_AT,    32'h0000_0000, 5'd3);
        drive_command(MD_DEL_AT,    32'h0000_0000, 5'd4);
        drive_command(MD_DEL_END,   32'h0000_0000, 5'd1);
        drive_command(MD_DEL_AT,    32'h0000_0000, 5'd1);
        // a freed slot gets reused
        drive_command(MD_INS_FRONT, 32'haaaa_aaaa, 5'd16);
        drive_command(MD_DUMP,      32'h0000_0000, 5'd1);
        drive_command(MD_DEL_FRONT, 32'h0000_0000, 5'd1);
        drive_command(MD_DEL_END,   32'h0000_0000, 5'd1);
        drive_command(MD_DUMP,      32'h0000_0000, 5'd1);

        filling = 1'b1;
        issued  = 0;
        while (issued < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 12);
            repeat (burst) begin
                pick_command(filling, m, v, p);
                drive_command(m, v, p);
                if (m != MODE_UNUSED)
                    issued++;
                // linger a little at full and empty so those cases get hit
                if (filling && list_sb.length == CAPACITY && $urandom_range(0, 3) == 0)
                    filling = 1'b0;
                else if (!filling && list_sb.length == 0 && $urandom_range(0, 2) == 0)
                    filling = 1'b1;
            end
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 6));
        end

        pause_sender(1);
        while (list_sb.due_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (list_sb.errors == 0)
            $display("tb_linked_list_manager_unit passed");
        else
            $display("tb_linked_list_manager_unit failed");
        $finish;
    end
endmodule

// ===== linked_list_manager_unit.f =====
hw/rtl/llm_pkg.sv
hw/rtl/llm_ram.sv
hw/rtl/llm_ctrl.sv
hw/rtl/linked_list_manager_unit.sv
dv/tb_linked_list_manager_unit.sv
